// ===== rtl/core/sgr_pkg.sv =====
// Stereo gain ramp package: shared widths, state and ramp codes, root table.
// No dependencies; used by the multiplier, the divider and the top level.
package sgr_pkg;

   localparam int FACTOR_FRAC = 30;
   localparam int MUL_W       = 33;
   localparam int PROD_W      = 66;
   localparam int DIVIDEND_W  = 36;
   localparam int LOG_W       = 35;

   typedef enum logic [1:0] {
      RAMP_HOLD   = 2'd0,
      RAMP_LINEAR = 2'd1,
      RAMP_EXP    = 2'd2
   } ramp_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOG_LOAD,
      ST_LOG_NORM,
      ST_LOG_SQ,
      ST_LOG_ACC,
      ST_DIV_LOAD,
      ST_DIV_WAIT,
      ST_DIV_DONE,
      ST_POW_MUL,
      ST_POW_ACC,
      ST_UPD_MUL,
      ST_UPD_FIN,
      ST_SCL_MUL,
      ST_SCL_FIN,
      ST_PUT
   } seq_state_type;

   typedef logic [30:1][31:0] root_tab_type;

   // bitwise integer square root, used only at elaboration
   function automatic logic [63:0] isqrt64(input logic [63:0] x);
      logic [63:0] rem;
      logic [63:0] r;
      logic [63:0] bit_v;
      rem   = x;
      r     = 64'd0;
      bit_v = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (rem >= r + bit_v) begin
            rem = rem - (r + bit_v);
            r   = (r >> 1) + bit_v;
         end else begin
            r = r >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return r;
   endfunction

   // 2^(2^-k) in Q2.30, each entry the truncated root of the previous one
   function automatic root_tab_type build_roots();
      root_tab_type t;
      logic [63:0]  c;
      c = 64'h8000_0000;
      for (int k = 1; k <= 30; k++) begin
         c    = isqrt64(c << FACTOR_FRAC);
         t[k] = c[31:0];
      end
      return t;
   endfunction

   localparam root_tab_type ROOT_TAB = build_roots();

   // gain times Q2.30 factor: truncate toward zero, saturate to 32 bits
   function automatic logic [31:0] gain_from_product(input logic [PROD_W-1:0] p);
      logic [PROD_W-1:0] mag;
      logic [PROD_W-1:0] sh;
      logic [PROD_W-1:0] v;
      mag = p[PROD_W-1] ? (~p + 66'd1) : p;
      sh  = mag >> FACTOR_FRAC;
      v   = p[PROD_W-1] ? (~sh + 66'd1) : sh;
      if (!p[PROD_W-1] && sh > 66'h7FFF_FFFF) begin
         v = 66'h7FFF_FFFF;
      end else if (p[PROD_W-1] && sh > 66'h8000_0000) begin
         v = 66'h3_FFFF_FFFF_8000_0000;
      end
      return v[31:0];
   endfunction

   // 33-bit signed sum saturated to 32 bits
   function automatic logic [31:0] sat_sum(input logic [32:0] s);
      logic [31:0] v;
      if (s[32] != s[31]) begin
         v = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         v = s[31:0];
      end
      return v;
   endfunction

endpackage

// ===== rtl/core/sgr_mul.sv =====
// Shared signed multiplier with registered product.
// Depends on sgr_pkg for operand and product widths.
module sgr_mul (
   input  logic                           clock,
   input  logic [sgr_pkg::MUL_W-1:0]      mul_a,
   input  logic [sgr_pkg::MUL_W-1:0]      mul_b,
   output logic [sgr_pkg::PROD_W-1:0]     product
);

   logic [sgr_pkg::PROD_W-1:0] product_ff;
   logic [sgr_pkg::PROD_W-1:0] product_in;

   assign product_in = sgr_pkg::PROD_W'($signed(mul_a) * $signed(mul_b));

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// ===== rtl/core/sgr_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
// Depends on sgr_pkg for the dividend width.
module sgr_div #(
   parameter int DIVISOR_W = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [sgr_pkg::DIVIDEND_W-1:0]    dividend,
   input  logic [DIVISOR_W-1:0]              divisor,
   output logic                              busy,
   output logic [sgr_pkg::DIVIDEND_W-1:0]    quotient
);

   localparam int CNT_W = $clog2(sgr_pkg::DIVIDEND_W + 1);

   logic [sgr_pkg::DIVIDEND_W-1:0] quot_ff, quot_in;
   logic [DIVISOR_W-1:0]           rem_ff, rem_in;
   logic [DIVISOR_W-1:0]           div_ff, div_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic [DIVISOR_W:0]             trial;
   logic [DIVISOR_W:0]             diff;
   logic                           ge;

   assign trial = {rem_ff, quot_ff[sgr_pkg::DIVIDEND_W-1]};
   assign ge    = trial >= {1'b0, div_ff};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CNT_W'(sgr_pkg::DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[sgr_pkg::DIVIDEND_W-2:0], ge};
         rem_in  = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         cnt_in  = cnt_ff - CNT_W'(1);
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign busy     = busy_ff;
   assign quotient = quot_ff;

endmodule

// ===== rtl/core/stereo_gain_ramp_unit.sv =====
// Stereo gain ramp unit: top level with sequencer, state and output register.
// Depends on sgr_pkg, sgr_mul and sgr_div.
//
// Usage:
//  - req channel: cmd 0 starts a chunk (new targets, chunk length), cmd 1 is a
//    sample pair. rsp channel: one result per sample pair, none per chunk.
//  - csr channel: exponential_mode bit, always ready, write only while idle.
//  - A sample pair runs through one shared 33x33 multiplier four times (two
//    gain updates, two scalings); the next request is taken only after the
//    result has gone to the output register.
//  - Linear chunk start: two passes of the divider, one per channel.
//    A chunk that keeps its targets finishes in the accept cycle.
//  - Exponential chunk start: per channel two log2 runs (normalize, then 30
//    squarings), one divide, and 30 multiply steps for 2^e.
//  - The sequencer takes one request at a time; req_ready is low while busy.
//  - Results sit in an output register; a new request is taken while an
//    earlier result waits, the sequencer only holds when a second result
//    is ready and rsp is still stalled.
//  - Reset: gains and kept targets go to 1.0, steps to zero, ramp to hold.
module stereo_gain_ramp_unit #(
   parameter int SAMPLE_WIDTH   = 32,
   parameter int GAIN_FRAC_BITS = 24,
   parameter int LENGTH_WIDTH   = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_cmd,
   input  logic [31:0]             req_left_sample,
   input  logic [31:0]             req_right_sample,
   input  logic [31:0]             req_target_left_gain,
   input  logic [31:0]             req_target_right_gain,
   input  logic [LENGTH_WIDTH-1:0] req_chunk_length,
   // response channel
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [31:0]             rsp_left_out,
   output logic [31:0]             rsp_right_out,
   output logic                    rsp_clipped,
   // control register
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic                    csr_exponential_mode
);

   localparam logic [31:0] GAIN_ONE = 32'd1 << GAIN_FRAC_BITS;
   localparam logic [sgr_pkg::PROD_W-1:0] SCL_HI =
      (66'd1 << (SAMPLE_WIDTH - 1)) - 66'd1;
   localparam logic [31:0] Q30_ONE = 32'h4000_0000;
   localparam logic [4:0]  LAST_ITER = 5'(sgr_pkg::FACTOR_FRAC);

   // product to sample: truncate toward zero, saturate to SAMPLE_WIDTH
   function automatic logic [32:0] scale_product(input logic [sgr_pkg::PROD_W-1:0] p);
      logic [sgr_pkg::PROD_W-1:0] mag;
      logic [sgr_pkg::PROD_W-1:0] sh;
      logic [sgr_pkg::PROD_W-1:0] v;
      logic                       clip;
      mag  = p[sgr_pkg::PROD_W-1] ? (~p + 66'd1) : p;
      sh   = mag >> GAIN_FRAC_BITS;
      v    = p[sgr_pkg::PROD_W-1] ? (~sh + 66'd1) : sh;
      clip = 1'b0;
      if (!p[sgr_pkg::PROD_W-1] && sh > SCL_HI) begin
         v    = SCL_HI;
         clip = 1'b1;
      end else if (p[sgr_pkg::PROD_W-1] && sh > SCL_HI + 66'd1) begin
         v    = ~SCL_HI;
         clip = 1'b1;
      end
      return {clip, v[31:0]};
   endfunction

   sgr_pkg::seq_state_type  state_ff, state_in;
   sgr_pkg::ramp_kind_type  kind_ff, kind_in;
   logic                    mode_ff, mode_in;
   logic                    ch_ff, ch_in;
   logic                    which_new_ff, which_new_in;
   logic [31:0]             gnow_ff [2];
   logic [31:0]             gnow_in [2];
   logic [31:0]             step_ff [2];
   logic [31:0]             step_in [2];
   logic [31:0]             kept_ff [2];
   logic [31:0]             kept_in [2];
   logic                    rsp_valid_ff, rsp_valid_in;

   // payload / work registers
   logic [LENGTH_WIDTH-1:0] len_ff, len_in;
   logic [SAMPLE_WIDTH-1:0] samp_ff [2];
   logic [SAMPLE_WIDTH-1:0] samp_in [2];
   logic [30:0]             m_ff, m_in;
   logic [4:0]              p_ff, p_in;
   logic [29:0]             frac_ff, frac_in;
   logic [4:0]              iter_ff, iter_in;
   logic [sgr_pkg::LOG_W-1:0] lnew_ff, lnew_in;
   logic [sgr_pkg::LOG_W-1:0] lold_ff, lold_in;
   logic                    neg_ff, neg_in;
   logic [31:0]             r_ff, r_in;
   logic [29:0]             fr_ff, fr_in;
   logic [5:0]              shift_ff, shift_in;
   logic [31:0]             out_ff [2];
   logic [31:0]             out_in [2];
   logic                    clip_ff, clip_in;
   logic [31:0]             rsp_left_ff, rsp_left_in;
   logic [31:0]             rsp_right_ff, rsp_right_in;
   logic                    rsp_clip_ff, rsp_clip_in;

   // shared units
   logic [sgr_pkg::MUL_W-1:0]      mul_a, mul_b;
   logic [sgr_pkg::PROD_W-1:0]     product;
   logic                           div_start;
   logic [sgr_pkg::DIVIDEND_W-1:0] div_dividend;
   logic                           div_busy;
   logic [sgr_pkg::DIVIDEND_W-1:0] div_quotient;

   logic                    req_take;
   logic [31:0]             cur_gain, cur_step, cur_kept, cur_samp_ext;
   logic [31:0]             log_src, log_abs;
   logic [32:0]             lin_diff, lin_mag;
   logic [sgr_pkg::DIVIDEND_W-1:0] exp_diff, exp_mag;
   logic [31:0]             sq;
   logic [29:0]             frac_next;
   logic [32:0]             scaled;
   logic [31:0]             r_next;
   logic                    sign_ok_l, sign_ok_r;
   logic [sgr_pkg::DIVIDEND_W-1:0] q_neg;

   sgr_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   sgr_div #(.DIVISOR_W(LENGTH_WIDTH)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (len_ff),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   assign req_ready = (state_ff == sgr_pkg::ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign cur_gain = gnow_ff[ch_ff];
   assign cur_step = step_ff[ch_ff];
   assign cur_kept = kept_ff[ch_ff];
   assign cur_samp_ext = 32'($signed(samp_ff[ch_ff]));

   // operand paths shared by the datapath
   assign log_src  = which_new_ff ? cur_kept : cur_gain;
   assign log_abs  = log_src[31] ? (~log_src + 32'd1) : log_src;
   assign lin_diff = {cur_kept[31], cur_kept} - {cur_gain[31], cur_gain};
   assign lin_mag  = lin_diff[32] ? (~lin_diff + 33'd1) : lin_diff;
   assign exp_diff = {1'b0, lnew_ff} - {1'b0, lold_ff};
   assign exp_mag  = exp_diff[sgr_pkg::DIVIDEND_W-1] ? (~exp_diff + 36'd1) : exp_diff;
   assign sq        = product[61:30];
   assign frac_next = {frac_ff[28:0], sq[31]};
   assign scaled    = scale_product(product);
   assign r_next    = product[61:30];
   assign q_neg     = ~div_quotient + 36'd1;

   // nonzero targets of the same sign on each side
   assign sign_ok_l = (kept_ff[0] != 32'd0) && (req_target_left_gain != 32'd0) &&
                      (kept_ff[0][31] == req_target_left_gain[31]);
   assign sign_ok_r = (kept_ff[1] != 32'd0) && (req_target_right_gain != 32'd0) &&
                      (kept_ff[1][31] == req_target_right_gain[31]);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         sgr_pkg::ST_LOG_SQ: begin
            mul_a = {2'b00, m_ff};
            mul_b = {2'b00, m_ff};
         end
         sgr_pkg::ST_POW_MUL: begin
            mul_a = {1'b0, r_ff};
            mul_b = fr_ff[5'd30 - iter_ff] ? {1'b0, sgr_pkg::ROOT_TAB[iter_ff]}
                                            : {1'b0, Q30_ONE};
         end
         sgr_pkg::ST_UPD_MUL: begin
            mul_a = {cur_gain[31], cur_gain};
            mul_b = {1'b0, cur_step};
         end
         sgr_pkg::ST_SCL_MUL: begin
            mul_a = {cur_samp_ext[31], cur_samp_ext};
            mul_b = {cur_gain[31], cur_gain};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      mode_in      = mode_ff;
      ch_in        = ch_ff;
      which_new_in = which_new_ff;
      gnow_in      = gnow_ff;
      step_in      = step_ff;
      kept_in      = kept_ff;
      rsp_valid_in = rsp_valid_ff;
      len_in       = len_ff;
      samp_in      = samp_ff;
      m_in         = m_ff;
      p_in         = p_ff;
      frac_in      = frac_ff;
      iter_in      = iter_ff;
      lnew_in      = lnew_ff;
      lold_in      = lold_ff;
      neg_in       = neg_ff;
      r_in         = r_ff;
      fr_in        = fr_ff;
      shift_in     = shift_ff;
      out_in       = out_ff;
      clip_in      = clip_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_clip_in  = rsp_clip_ff;
      div_start    = 1'b0;
      div_dividend = '0;

      if (csr_valid) begin
         mode_in = csr_exponential_mode;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         sgr_pkg::ST_IDLE: begin
            if (req_take) begin
               ch_in = 1'b0;
               if (req_cmd) begin
                  samp_in[0] = req_left_sample[SAMPLE_WIDTH-1:0];
                  samp_in[1] = req_right_sample[SAMPLE_WIDTH-1:0];
                  clip_in    = 1'b0;
                  state_in   = sgr_pkg::ST_UPD_MUL;
               end else begin
                  len_in     = (req_chunk_length == '0) ? LENGTH_WIDTH'(1)
                                                        : req_chunk_length;
                  gnow_in[0] = kept_ff[0];
                  gnow_in[1] = kept_ff[1];
                  kept_in[0] = req_target_left_gain;
                  kept_in[1] = req_target_right_gain;
                  if (req_target_left_gain == kept_ff[0] &&
                      req_target_right_gain == kept_ff[1]) begin
                     kind_in    = sgr_pkg::RAMP_HOLD;
                     step_in[0] = '0;
                     step_in[1] = '0;
                  end else if (mode_ff && sign_ok_l && sign_ok_r) begin
                     kind_in      = sgr_pkg::RAMP_EXP;
                     which_new_in = 1'b1;
                     state_in     = sgr_pkg::ST_LOG_LOAD;
                  end else begin
                     kind_in  = sgr_pkg::RAMP_LINEAR;
                     state_in = sgr_pkg::ST_DIV_LOAD;
                  end
               end
            end
         end

         // log2: normalize mantissa into [2^30, 2^31)
         sgr_pkg::ST_LOG_LOAD: begin
            if (log_abs[31]) begin
               m_in = log_abs[31:1];
               p_in = 5'd31;
            end else begin
               m_in = log_abs[30:0];
               p_in = 5'd30;
            end
            frac_in  = '0;
            iter_in  = 5'd1;
            state_in = sgr_pkg::ST_LOG_NORM;
         end
         sgr_pkg::ST_LOG_NORM: begin
            if (m_ff[30]) begin
               state_in = sgr_pkg::ST_LOG_SQ;
            end else begin
               m_in = {m_ff[29:0], 1'b0};
               p_in = p_ff - 5'd1;
            end
         end
         sgr_pkg::ST_LOG_SQ: begin
            state_in = sgr_pkg::ST_LOG_ACC;
         end
         sgr_pkg::ST_LOG_ACC: begin
            frac_in = frac_next;
            m_in    = sq[31] ? sq[31:1] : sq[30:0];
            if (iter_ff == LAST_ITER) begin
               if (which_new_ff) begin
                  lnew_in      = {p_ff, frac_next};
                  which_new_in = 1'b0;
                  state_in     = sgr_pkg::ST_LOG_LOAD;
               end else begin
                  lold_in  = {p_ff, frac_next};
                  state_in = sgr_pkg::ST_DIV_LOAD;
               end
            end else begin
               iter_in  = iter_ff + 5'd1;
               state_in = sgr_pkg::ST_LOG_SQ;
            end
         end

         sgr_pkg::ST_DIV_LOAD: begin
            div_start = 1'b1;
            if (kind_ff == sgr_pkg::RAMP_LINEAR) begin
               div_dividend = {3'b000, lin_mag};
               neg_in       = lin_diff[32];
            end else begin
               div_dividend = exp_mag;
               neg_in       = exp_diff[sgr_pkg::DIVIDEND_W-1];
            end
            state_in = sgr_pkg::ST_DIV_WAIT;
         end
         sgr_pkg::ST_DIV_WAIT: begin
            if (!div_busy) begin
               state_in = sgr_pkg::ST_DIV_DONE;
            end
         end
         sgr_pkg::ST_DIV_DONE: begin
            if (kind_ff == sgr_pkg::RAMP_LINEAR) begin
               if (!neg_ff) begin
                  step_in[ch_ff] = (div_quotient > 36'h7FFF_FFFF) ? 32'h7FFF_FFFF
                                                                 : div_quotient[31:0];
               end else begin
                  step_in[ch_ff] = (div_quotient > 36'h8000_0000) ? 32'h8000_0000
                                                                 : q_neg[31:0];
               end
               ch_in    = 1'b1;
               state_in = ch_ff ? sgr_pkg::ST_IDLE : sgr_pkg::ST_DIV_LOAD;
            end else if (!neg_ff && div_quotient >= 36'h4000_0000) begin
               // factor of two or more saturates
               step_in[ch_ff] = 32'h7FFF_FFFF;
               ch_in          = 1'b1;
               which_new_in   = 1'b1;
               state_in       = ch_ff ? sgr_pkg::ST_IDLE : sgr_pkg::ST_LOG_LOAD;
            end else begin
               r_in    = Q30_ONE;
               iter_in = 5'd1;
               if (!neg_ff) begin
                  fr_in    = div_quotient[29:0];
                  shift_in = '0;
               end else begin
                  fr_in    = q_neg[29:0];
                  shift_in = div_quotient[35:30] + 6'(|div_quotient[29:0]);
               end
               state_in = sgr_pkg::ST_POW_MUL;
            end
         end

         // 2^e: one root constant per fraction bit
         sgr_pkg::ST_POW_MUL: begin
            state_in = sgr_pkg::ST_POW_ACC;
         end
         sgr_pkg::ST_POW_ACC: begin
            r_in = r_next;
            if (iter_ff == LAST_ITER) begin
               step_in[ch_ff] = r_next >> shift_ff;
               ch_in          = 1'b1;
               which_new_in   = 1'b1;
               state_in       = ch_ff ? sgr_pkg::ST_IDLE : sgr_pkg::ST_LOG_LOAD;
            end else begin
               iter_in  = iter_ff + 5'd1;
               state_in = sgr_pkg::ST_POW_MUL;
            end
         end

         // per-sample gain update then scaling, left then right
         sgr_pkg::ST_UPD_MUL: begin
            state_in = sgr_pkg::ST_UPD_FIN;
         end
         sgr_pkg::ST_UPD_FIN: begin
            case (kind_ff)
               sgr_pkg::RAMP_LINEAR:
                  gnow_in[ch_ff] = sgr_pkg::sat_sum({cur_gain[31], cur_gain} +
                                                    {cur_step[31], cur_step});
               sgr_pkg::RAMP_EXP:
                  gnow_in[ch_ff] = sgr_pkg::gain_from_product(product);
               default:
                  gnow_in[ch_ff] = cur_gain;
            endcase
            ch_in    = ~ch_ff;
            state_in = ch_ff ? sgr_pkg::ST_SCL_MUL : sgr_pkg::ST_UPD_MUL;
         end
         sgr_pkg::ST_SCL_MUL: begin
            state_in = sgr_pkg::ST_SCL_FIN;
         end
         sgr_pkg::ST_SCL_FIN: begin
            out_in[ch_ff] = scaled[31:0];
            clip_in       = clip_ff | scaled[32];
            ch_in         = ~ch_ff;
            state_in      = ch_ff ? sgr_pkg::ST_PUT : sgr_pkg::ST_SCL_MUL;
         end
         sgr_pkg::ST_PUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = out_ff[0];
               rsp_right_in = out_ff[1];
               rsp_clip_in  = clip_ff;
               state_in     = sgr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sgr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sgr_pkg::ST_IDLE;
         kind_ff      <= sgr_pkg::RAMP_HOLD;
         mode_ff      <= 1'b0;
         ch_ff        <= 1'b0;
         which_new_ff <= 1'b0;
         gnow_ff[0]   <= GAIN_ONE;
         gnow_ff[1]   <= GAIN_ONE;
         step_ff[0]   <= '0;
         step_ff[1]   <= '0;
         kept_ff[0]   <= GAIN_ONE;
         kept_ff[1]   <= GAIN_ONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         mode_ff      <= mode_in;
         ch_ff        <= ch_in;
         which_new_ff <= which_new_in;
         gnow_ff      <= gnow_in;
         step_ff      <= step_in;
         kept_ff      <= kept_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff       <= len_in;
      samp_ff      <= samp_in;
      m_ff         <= m_in;
      p_ff         <= p_in;
      frac_ff      <= frac_in;
      iter_ff      <= iter_in;
      lnew_ff      <= lnew_in;
      lold_ff      <= lold_in;
      neg_ff       <= neg_in;
      r_ff         <= r_in;
      fr_ff        <= fr_in;
      shift_ff     <= shift_in;
      out_ff       <= out_in;
      clip_ff      <= clip_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_clip_ff  <= rsp_clip_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_left_ff;
   assign rsp_right_out = rsp_right_ff;
   assign rsp_clipped   = rsp_clip_ff;

endmodule

// ===== rtl/core/sgr_checker.sv =====
// Port-level checks for the stereo gain ramp unit, bound to the top level.
// Depends only on the top level's ports.
module sgr_checker #(
   parameter int SAMPLE_WIDTH = 32
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_cmd,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_left_out,
   input logic [31:0] rsp_right_out,
   input logic        rsp_clipped
);

   localparam logic [31:0] OUT_MAX = 32'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
   localparam logic [31:0] OUT_MIN = ~OUT_MAX;

   // stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // clip flag only with a saturated channel
   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |->
         (rsp_left_out == OUT_MAX || rsp_left_out == OUT_MIN ||
          rsp_right_out == OUT_MAX || rsp_right_out == OUT_MIN))
      else $error("clip flag without saturated output");

   // a sample request keeps the sequencer busy
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd |=> !req_ready)
      else $error("ready right after a sample request");

endmodule

bind stereo_gain_ramp_unit sgr_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_sgr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_cmd       (req_cmd),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_left_out  (rsp_left_out),
   .rsp_right_out (rsp_right_out),
   .rsp_clipped   (rsp_clipped)
);
